// ===== src/cfs_pkg.sv =====
// Shared constants, codes and types for the circular FIFO with search.
package cfs_pkg;

    localparam int DEPTH = 8;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_SEARCH = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctrl;

endpackage

// ===== src/cfs_cell.sv =====
// One storage cell of the queue: holds a word, shifts toward the front and compares.
module cfs_cell (
    input  logic                             i_clk,
    input  cfs_pkg::t_cell_ctrl              i_ctrl,
    input  logic signed [cfs_pkg::WORD_W-1:0] i_upper_word,
    input  logic signed [cfs_pkg::WORD_W-1:0] i_data_word,
    input  logic                             i_occupied,
    output logic signed [cfs_pkg::WORD_W-1:0] o_word,
    output logic signed [cfs_pkg::WORD_W-1:0] o_next_word,
    output logic                             o_match
);

    logic signed [cfs_pkg::WORD_W-1:0] r_word;
    logic signed [cfs_pkg::WORD_W-1:0] n_word;

    // A pop moves every word one cell toward the front; a push loads the first free cell.
    always_comb begin
        n_word = r_word;
        if (i_ctrl.shift) begin
            n_word = i_upper_word;
        end else if (i_ctrl.load) begin
            n_word = i_data_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word      = r_word;
    assign o_next_word = n_word;
    assign o_match     = i_occupied && (r_word == i_data_word);

endmodule

// ===== src/circular_fifo_with_search.sv =====
// Top level of the FIFO with search: a row of word cells, occupancy count and result register.
//
// Input channel: i_in_valid, o_in_stall, i_opcode, i_data_word. A request is taken at
// a rising edge with i_in_valid high and o_in_stall low. Opcode push appends the word,
// pop removes the oldest word, search compares the word against all stored entries.
// Output channel: o_out_valid, i_out_stall and the result fields. Each request yields
// exactly one result, registered in the cycle after the request is taken; it reports
// the status, any popped word, the match flag and the front, rear, empty and full
// state after the request.
// Throughput is one request per cycle unless a result waits under i_out_stall: all cells
// shift, load and compare in the same cycle, updating the cell row and the occupancy counter.
// While a result waits under i_out_stall, o_in_stall is raised and the result holds;
// a new request is taken in the same cycle the pending result leaves.
// Reset (i_rst_n low at a clock edge) empties the queue and drops any pending result;
// cell contents are not cleared, since only occupied cells are ever read.
module circular_fifo_with_search (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_opcode,
    input  logic signed [cfs_pkg::WORD_W-1:0] i_data_word,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [1:0]                        o_status,
    output logic signed [cfs_pkg::WORD_W-1:0] o_popped_word,
    output logic                              o_match_found,
    output logic signed [cfs_pkg::WORD_W-1:0] o_front_word,
    output logic signed [cfs_pkg::WORD_W-1:0] o_rear_word,
    output logic                              o_queue_empty,
    output logic                              o_queue_full
);

    localparam int D = cfs_pkg::DEPTH;

    logic [cfs_pkg::CNT_W-1:0] r_count;
    logic [cfs_pkg::CNT_W-1:0] n_count;
    logic [cfs_pkg::CNT_W-1:0] rear_pos;
    logic                      r_out_valid;
    logic                      accept;
    logic                      is_empty;
    logic                      is_full;
    logic                      push_ok;
    logic                      pop_ok;
    logic                      any_match;
    cfs_pkg::t_op              op;
    cfs_pkg::t_status          n_status;
    logic                      n_found;

    logic signed [cfs_pkg::WORD_W-1:0] cell_word [D];
    logic signed [cfs_pkg::WORD_W-1:0] cell_next [D];
    logic [D-1:0]                      cell_match;
    cfs_pkg::t_cell_ctrl               cell_ctrl [D];

    logic [1:0]                        r_status;
    logic signed [cfs_pkg::WORD_W-1:0] r_popped;
    logic                              r_found;
    logic signed [cfs_pkg::WORD_W-1:0] r_front;
    logic signed [cfs_pkg::WORD_W-1:0] r_rear;
    logic                              r_empty;
    logic                              r_full;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign op         = cfs_pkg::t_op'(i_opcode);
    assign is_empty   = (r_count == '0);
    assign is_full    = (r_count == cfs_pkg::CNT_W'(D));
    assign any_match  = |cell_match;

    always_comb begin
        push_ok  = 1'b0;
        pop_ok   = 1'b0;
        n_found  = 1'b0;
        n_status = cfs_pkg::ST_DONE;
        unique case (op)
            cfs_pkg::OP_PUSH: begin
                if (is_full) begin
                    n_status = cfs_pkg::ST_FULL;
                end else begin
                    push_ok = accept;
                end
            end
            cfs_pkg::OP_POP: begin
                if (is_empty) begin
                    n_status = cfs_pkg::ST_EMPTY;
                end else begin
                    pop_ok = accept;
                end
            end
            cfs_pkg::OP_SEARCH: begin
                if (is_empty) begin
                    n_status = cfs_pkg::ST_EMPTY;
                end else begin
                    n_found = any_match;
                end
            end
            cfs_pkg::OP_NONE: begin
                n_status = cfs_pkg::ST_DONE;
            end
            default: begin
                n_status = cfs_pkg::ST_DONE;
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (push_ok) begin
            n_count = r_count + 1'b1;
        end else if (pop_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    assign rear_pos = n_count - 1'b1;

    genvar k;
    generate
        for (k = 0; k < D; k++) begin : g_cell
            logic signed [cfs_pkg::WORD_W-1:0] upper;

            if (k == D - 1) begin : g_last
                assign upper = cell_word[k];
            end else begin : g_mid
                assign upper = cell_word[k + 1];
            end

            assign cell_ctrl[k].shift = pop_ok;
            assign cell_ctrl[k].load  = push_ok && (r_count == cfs_pkg::CNT_W'(k));

            cfs_cell u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (cell_ctrl[k]),
                .i_upper_word (upper),
                .i_data_word  (i_data_word),
                .i_occupied   (r_count > cfs_pkg::CNT_W'(k)),
                .o_word       (cell_word[k]),
                .o_next_word  (cell_next[k]),
                .o_match      (cell_match[k])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The result reports the queue as it stands after the request.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_popped <= pop_ok ? cell_word[0] : '0;
            r_found  <= n_found;
            r_front  <= (n_count != '0) ? cell_next[0] : '0;
            r_rear   <= (n_count != '0) ? cell_next[rear_pos[cfs_pkg::IDX_W-1:0]] : '0;
            r_empty  <= (n_count == '0);
            r_full   <= (n_count == cfs_pkg::CNT_W'(D));
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_popped_word = r_popped;
    assign o_match_found = r_found;
    assign o_front_word  = r_front;
    assign o_rear_word   = r_rear;
    assign o_queue_empty = r_empty;
    assign o_queue_full  = r_full;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= cfs_pkg::CNT_W'(D))
        else $error("occupancy exceeds depth");

    a_flags_track_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_queue_empty == (r_count == '0))
                     && (o_queue_full == (r_count == cfs_pkg::CNT_W'(D))))
        else $error("reported empty or full flag disagrees with occupancy");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == cfs_pkg::ST_FULL) |-> o_queue_full)
        else $error("refused push reported while queue not full");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_ok |=> (r_count == $past(r_count) + 1'b1))
        else $error("accepted push did not grow the queue");

endmodule

// ===== test/cfs_checker.sv =====
// Checker for the circular FIFO with search: watches both channels, predicts and compares.
module cfs_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic [1:0]                        i_opcode,
    input  logic signed [cfs_pkg::WORD_W-1:0] i_data_word,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic [1:0]                        i_status,
    input  logic signed [cfs_pkg::WORD_W-1:0] i_popped_word,
    input  logic                              i_match_found,
    input  logic signed [cfs_pkg::WORD_W-1:0] i_front_word,
    input  logic signed [cfs_pkg::WORD_W-1:0] i_rear_word,
    input  logic                              i_queue_empty,
    input  logic                              i_queue_full,
    output int                                o_fail_count,
    output int                                o_pending
);

    typedef struct packed {
        logic [1:0]                 status;
        logic [cfs_pkg::WORD_W-1:0] popped;
        logic                       found;
        logic [cfs_pkg::WORD_W-1:0] front;
        logic [cfs_pkg::WORD_W-1:0] rear;
        logic                       empty;
        logic                       full;
    } t_fifo_result;

    logic [cfs_pkg::WORD_W-1:0] fifo_words [cfs_pkg::DEPTH];
    logic [cfs_pkg::IDX_W-1:0]  fifo_head;
    logic [cfs_pkg::IDX_W-1:0]  fifo_tail;
    logic [cfs_pkg::CNT_W-1:0]  fifo_count;
    t_fifo_result               expected_results [$];
    int                         mismatch_count = 0;

    function automatic logic [cfs_pkg::IDX_W-1:0] slot_after(
        input logic [cfs_pkg::IDX_W-1:0] slot);
        return (slot == cfs_pkg::DEPTH - 1) ? '0 : slot + 1'b1;
    endfunction

    // Applies one request to the shadow queue and returns the result it should produce.
    function automatic t_fifo_result predict_result(input logic [1:0] op,
                                                    input logic [cfs_pkg::WORD_W-1:0] word);
        t_fifo_result              r;
        logic [cfs_pkg::IDX_W-1:0] slot;
        r = '0;
        case (cfs_pkg::t_op'(op))
            cfs_pkg::OP_PUSH: begin
                if (fifo_count == cfs_pkg::DEPTH) begin
                    r.status = cfs_pkg::ST_FULL;
                end else begin
                    fifo_words[fifo_tail] = word;
                    fifo_tail = slot_after(fifo_tail);
                    fifo_count = fifo_count + 1'b1;
                end
            end
            cfs_pkg::OP_POP: begin
                if (fifo_count == 0) begin
                    r.status = cfs_pkg::ST_EMPTY;
                end else begin
                    r.popped = fifo_words[fifo_head];
                    fifo_head = slot_after(fifo_head);
                    fifo_count = fifo_count - 1'b1;
                end
            end
            cfs_pkg::OP_SEARCH: begin
                if (fifo_count == 0) begin
                    r.status = cfs_pkg::ST_EMPTY;
                end else begin
                    slot = fifo_head;
                    for (int k = 0; k < fifo_count; k++) begin
                        if (fifo_words[slot] == word)
                            r.found = 1'b1;
                        slot = slot_after(slot);
                    end
                end
            end
            default: ;
        endcase
        if (fifo_count != 0) begin
            r.front = fifo_words[fifo_head];
            r.rear = fifo_words[(fifo_tail == 0) ? cfs_pkg::DEPTH - 1 : fifo_tail - 1'b1];
        end
        r.empty = (fifo_count == 0);
        r.full = (fifo_count == cfs_pkg::DEPTH);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_fifo_result want;
        t_fifo_result got;
        if (!i_rst_n) begin
            fifo_head = '0;
            fifo_tail = '0;
            fifo_count = '0;
            expected_results.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(predict_result(i_opcode, i_data_word));
            if (i_out_valid && !i_out_stall) begin
                got = '{i_status, i_popped_word, i_match_found, i_front_word, i_rear_word,
                        i_queue_empty, i_queue_full};
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result with no request outstanding: status=%0d popped=%h",
                                 got.status, got.popped);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("mismatch: expected status=%0d popped=%h found=%0b",
                                     want.status, want.popped, want.found);
                            $display("          front=%h rear=%h empty=%0b full=%0b",
                                     want.front, want.rear, want.empty, want.full);
                            $display("          got status=%0d popped=%h found=%0b",
                                     got.status, got.popped, got.found);
                            $display("          front=%h rear=%h empty=%0b full=%0b",
                                     got.front, got.rear, got.empty, got.full);
                        end
                    end
                end
            end
        end
        o_fail_count <= mismatch_count;
        o_pending <= expected_results.size();
    end

endmodule

// ===== test/tb.sv =====
// Testbench top for the circular FIFO with search: stimulus, receiver stalls and verdict.
module tb;

    localparam int ITEM_COUNT = 1050;
    localparam int DIRECTED_COUNT = 25;
    localparam int QUIET_TAIL = 200;
    localparam int HOLD_CYCLES = 40;
    localparam int CYCLE_LIMIT = 100000;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              in_valid = 1'b0;
    logic                              in_stall;
    logic [1:0]                        opcode = cfs_pkg::OP_NONE;
    logic signed [cfs_pkg::WORD_W-1:0] data_word = '0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic [1:0]                        status;
    logic signed [cfs_pkg::WORD_W-1:0] popped_word;
    logic                              match_found;
    logic signed [cfs_pkg::WORD_W-1:0] front_word;
    logic signed [cfs_pkg::WORD_W-1:0] rear_word;
    logic                              queue_empty;
    logic                              queue_full;
    int                                fail_count;
    int                                pending;
    int                                cycles = 0;
    logic                              idle_on = 1'b1;
    logic                              hold_req = 1'b0;
    logic                              hold_done = 1'b0;
    logic [cfs_pkg::WORD_W-1:0]        pushed_words [$];

    circular_fifo_with_search u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_opcode      (opcode),
        .i_data_word   (data_word),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_status      (status),
        .o_popped_word (popped_word),
        .o_match_found (match_found),
        .o_front_word  (front_word),
        .o_rear_word   (rear_word),
        .o_queue_empty (queue_empty),
        .o_queue_full  (queue_full)
    );

    cfs_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_opcode      (opcode),
        .i_data_word   (data_word),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_status      (status),
        .i_popped_word (popped_word),
        .i_match_found (match_found),
        .i_front_word  (front_word),
        .i_rear_word   (rear_word),
        .i_queue_empty (queue_empty),
        .i_queue_full  (queue_full),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Receiver side: short random stall bursts, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req && !hold_done) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_done = 1'b1;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Offers one request, waits until it is taken, then sometimes drops in_valid for a random idle gap.
    task automatic send_req(input logic [1:0] op, input logic [cfs_pkg::WORD_W-1:0] word);
        in_valid <= 1'b1;
        opcode <= op;
        data_word <= word;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    // Mix of extremes, small values that repeat often, and full random words.
    function automatic logic [cfs_pkg::WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return '1;
            4, 5: return $urandom_range(0, 15);
            default: return $urandom();
        endcase
    endfunction

    // The sender goes quiet and waits until every outstanding request has produced a result.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin
        int                         push_pct;
        int                         pop_pct;
        int                         roll;
        logic [1:0]                 op;
        logic [cfs_pkg::WORD_W-1:0] word;
        push_pct = 40;
        pop_pct = 30;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Refusals on an empty queue, fill to full, a refused push, then drain past empty.
        send_req(cfs_pkg::OP_SEARCH, 32'h0000_0001);
        send_req(cfs_pkg::OP_POP, 32'hffff_ffff);
        send_req(cfs_pkg::OP_PUSH, 32'h7fff_ffff);
        send_req(cfs_pkg::OP_PUSH, 32'h8000_0000);
        send_req(cfs_pkg::OP_PUSH, 32'h0000_0000);
        send_req(cfs_pkg::OP_PUSH, 32'hffff_ffff);
        for (int i = 1; i <= 4; i++)
            send_req(cfs_pkg::OP_PUSH, i);
        send_req(cfs_pkg::OP_PUSH, 32'h0000_0005);
        send_req(cfs_pkg::OP_SEARCH, 32'h8000_0000);
        send_req(cfs_pkg::OP_SEARCH, 32'hffff_ffff);
        send_req(cfs_pkg::OP_SEARCH, 32'd12345);
        send_req(cfs_pkg::OP_NONE, 32'haaaa_5555);
        repeat (cfs_pkg::DEPTH) send_req(cfs_pkg::OP_POP, 32'h5555_aaaa);
        send_req(cfs_pkg::OP_POP, 32'h0);
        send_req(cfs_pkg::OP_NONE, 32'h0);

        for (int k = 0; k < ITEM_COUNT - DIRECTED_COUNT; k++) begin
            // Phases lean toward filling, draining or neither, so full and empty both recur.
            if (k % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0: begin push_pct = 60; pop_pct = 20; end
                    1: begin push_pct = 20; pop_pct = 60; end
                    default: begin push_pct = 40; pop_pct = 35; end
                endcase
            end
            if (k == 300)
                hold_req = 1'b1;
            if (k == 600)
                drain();
            if (k == ITEM_COUNT - DIRECTED_COUNT - QUIET_TAIL)
                idle_on = 1'b0;
            roll = $urandom_range(0, 99);
            word = pick_word();
            if (roll < 3) begin
                op = cfs_pkg::OP_NONE;
            end else if (roll < 3 + push_pct) begin
                op = cfs_pkg::OP_PUSH;
                pushed_words.push_back(word);
                if (pushed_words.size() > 12)
                    void'(pushed_words.pop_front());
            end else if (roll < 3 + push_pct + pop_pct) begin
                op = cfs_pkg::OP_POP;
            end else begin
                op = cfs_pkg::OP_SEARCH;
                if (pushed_words.size() != 0 && $urandom_range(0, 1) == 1)
                    word = pushed_words[$urandom_range(0, pushed_words.size() - 1)];
            end
            send_req(op, word);
        end

        drain();
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/cfs_pkg.sv
src/cfs_cell.sv
src/circular_fifo_with_search.sv
test/cfs_checker.sv
test/tb.sv
